>>> hw/rtl/cidf_pkg.sv
`timescale 1ns / 1ps

package cidf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int W_W      = 24;
   localparam int PROD_W   = COEF_W + W_W;
   localparam int ACC_W    = 44;
   localparam int FRAC_SH  = 13;
   localparam int RND_W    = ACC_W - FRAC_SH;
   localparam int TAPS_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int MAX_TAPS = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FB_TAPS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FF_TAPS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FB_01   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB_23   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FF_01   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FF_23   = 3'd5;

   localparam logic [CSR_DATA_W-1:0] FF_01_RESET = 64'd8192;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FB    = 5'b00010,
      ST_WCALC = 5'b00100,
      ST_FF    = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic signed [W_W-1:0] re;
      logic signed [W_W-1:0] im;
   } wval_type;

endpackage

>>> hw/rtl/complex_iir_direct_form_two.sv
`timescale 1ns / 1ps

// Complex direct form II IIR filter. Each transaction on req_ carries one complex Q1.15 sample
// and gives exactly one saturated Q1.15 complex result on rsp_. The feedback sum over the
// stored intermediate values is formed first, the new intermediate value (24 bits per part,
// saturated) is written to a circular delay memory whose pointer moves backward, then the
// feedforward sum gives the output. All complex multiply-accumulates go one tap per cycle
// through a single shared complex multiplier fed by the one read port of the delay memory.
// req_stall is high from acceptance of a sample until its result enters the output register.
// A finished result waits in the output register, so the next sample can be accepted while
// it is still stalled. Taps are limited to four and to DELAY_DEPTH. Configuration must be
// written through csr_ only while no transaction is in flight; the user is bound by this,
// and the block itself does not enforce it.
module complex_iir_direct_form_two #(
   parameter int DELAY_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_wr_en,
   input  logic [cidf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cidf_pkg::CSR_DATA_W-1:0]       csr_wdata,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cidf_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [cidf_pkg::SAMPLE_W-1:0]  req_sample_im,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cidf_pkg::SAMPLE_W-1:0]  rsp_out_re,
   output logic signed [cidf_pkg::SAMPLE_W-1:0]  rsp_out_im
);

   localparam int PW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int TAP_LIM_I = (DELAY_DEPTH < cidf_pkg::MAX_TAPS) ? DELAY_DEPTH
                                                                  : cidf_pkg::MAX_TAPS;
   localparam logic [cidf_pkg::TAPS_W-1:0] TAP_LIM = cidf_pkg::TAPS_W'(TAP_LIM_I);
   localparam int W_W = cidf_pkg::W_W;
   localparam int ACC_W = cidf_pkg::ACC_W;
   localparam int RND_W = cidf_pkg::RND_W;
   localparam int PROD_W = cidf_pkg::PROD_W;

   // configuration registers
   logic [cidf_pkg::TAPS_W-1:0]     fb_taps_ff;
   logic [cidf_pkg::TAPS_W-1:0]     ff_taps_ff;
   logic [cidf_pkg::CSR_DATA_W-1:0] coef_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_taps_ff <= '0;
         ff_taps_ff <= cidf_pkg::TAPS_W'(1);
         coef_ff[0] <= '0;
         coef_ff[1] <= '0;
         coef_ff[2] <= cidf_pkg::FF_01_RESET;
         coef_ff[3] <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == cidf_pkg::REG_FB_TAPS) fb_taps_ff <= csr_wdata[cidf_pkg::TAPS_W-1:0];
         if (csr_index == cidf_pkg::REG_FF_TAPS) ff_taps_ff <= csr_wdata[cidf_pkg::TAPS_W-1:0];
         if (csr_index == cidf_pkg::REG_FB_01) coef_ff[0] <= csr_wdata;
         if (csr_index == cidf_pkg::REG_FB_23) coef_ff[1] <= csr_wdata;
         if (csr_index == cidf_pkg::REG_FF_01) coef_ff[2] <= csr_wdata;
         if (csr_index == cidf_pkg::REG_FF_23) coef_ff[3] <= csr_wdata;
      end
   end

   // sequencer and datapath registers
   cidf_pkg::state_type              state_ff, state_in;
   logic [cidf_pkg::TAPS_W-1:0]      cnt_ff, cnt_in;
   logic [PW-1:0]                    ptr_ff, ptr_in;
   logic signed [cidf_pkg::SAMPLE_W-1:0] x_re_ff, x_re_in, x_im_ff, x_im_in;
   logic signed [ACC_W-1:0]          acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                             s1_ff, s1_in, s2_ff, s2_in;
   logic [1:0]                       k_s1_ff, k_s1_in;
   logic signed [PROD_W-1:0]         p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [cidf_pkg::SAMPLE_W-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;

   // delay memory with per-entry valid bits
   cidf_pkg::wval_type               delay_ff [DELAY_DEPTH];
   logic [DELAY_DEPTH-1:0]           vld_ff;
   cidf_pkg::wval_type               rd_data_ff;
   logic                             rd_vld_ff;

   logic                             rd_en;
   logic [PW-1:0]                    rd_addr;
   logic                             wr_en;
   cidf_pkg::wval_type               wr_data;

   logic [cidf_pkg::TAPS_W-1:0]      lim;
   logic                             bank;
   logic [PW+1:0]                    addr_sum;
   logic [PW-1:0]                    ptr_dec;
   logic [cidf_pkg::CSR_DATA_W/2-1:0] coef_half;
   logic signed [cidf_pkg::COEF_W-1:0] c_re, c_im;
   logic signed [W_W-1:0]            d_re, d_im;
   logic                             req_acc;
   logic                             out_free;

   logic signed [ACC_W-1:0]          wv_re, wv_im;
   logic signed [RND_W-1:0]          wr_re, wr_im, yr_re, yr_im;
   logic signed [W_W-1:0]            w_re_sat, w_im_sat;

   assign req_stall = (state_ff != cidf_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign bank = (state_ff == cidf_pkg::ST_FF);
   always_comb begin
      lim = bank ? ff_taps_ff : fb_taps_ff;
      if (lim > TAP_LIM) lim = TAP_LIM;
   end

   assign addr_sum = {2'b00, ptr_ff} + (PW+2)'(cnt_ff);
   assign rd_addr  = (addr_sum >= (PW+2)'(DELAY_DEPTH))
                     ? PW'(addr_sum - (PW+2)'(DELAY_DEPTH)) : PW'(addr_sum);
   assign ptr_dec  = (ptr_ff == '0) ? PW'(DELAY_DEPTH - 1) : ptr_ff - PW'(1);

   // coefficient select for the tap now in the multiplier
   assign coef_half = k_s1_ff[0] ? coef_ff[{bank, k_s1_ff[1]}][63:32]
                                 : coef_ff[{bank, k_s1_ff[1]}][31:0];
   assign c_re = coef_half[15:0];
   assign c_im = coef_half[31:16];
   assign d_re = rd_vld_ff ? rd_data_ff.re : '0;
   assign d_im = rd_vld_ff ? rd_data_ff.im : '0;

   // intermediate value: x - feedback sum, round half up, saturate
   assign wv_re = ($signed({{(ACC_W-cidf_pkg::SAMPLE_W){x_re_ff[15]}}, x_re_ff})
                   <<< cidf_pkg::FRAC_SH) - acc_re_ff;
   assign wv_im = ($signed({{(ACC_W-cidf_pkg::SAMPLE_W){x_im_ff[15]}}, x_im_ff})
                   <<< cidf_pkg::FRAC_SH) - acc_im_ff;
   assign wr_re = RND_W'((wv_re + ACC_W'(4096)) >>> cidf_pkg::FRAC_SH);
   assign wr_im = RND_W'((wv_im + ACC_W'(4096)) >>> cidf_pkg::FRAC_SH);
   assign yr_re = RND_W'((acc_re_ff + ACC_W'(4096)) >>> cidf_pkg::FRAC_SH);
   assign yr_im = RND_W'((acc_im_ff + ACC_W'(4096)) >>> cidf_pkg::FRAC_SH);

   always_comb begin
      if (wr_re > 31'sd8388607)       w_re_sat = 24'sh7FFFFF;
      else if (wr_re < -31'sd8388608) w_re_sat = -24'sd8388608;
      else                            w_re_sat = wr_re[W_W-1:0];
      if (wr_im > 31'sd8388607)       w_im_sat = 24'sh7FFFFF;
      else if (wr_im < -31'sd8388608) w_im_sat = -24'sd8388608;
      else                            w_im_sat = wr_im[W_W-1:0];
      if (yr_re > 31'sd32767)         out_re_in = 16'sh7FFF;
      else if (yr_re < -31'sd32768)   out_re_in = -16'sd32768;
      else                            out_re_in = yr_re[15:0];
      if (yr_im > 31'sd32767)         out_im_in = 16'sh7FFF;
      else if (yr_im < -31'sd32768)   out_im_in = -16'sd32768;
      else                            out_im_in = yr_im[15:0];
   end

   assign wr_data.re = w_re_sat;
   assign wr_data.im = w_im_sat;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      x_re_in   = x_re_ff;
      x_im_in   = x_im_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      s1_in     = 1'b0;
      k_s1_in   = k_s1_ff;
      s2_in     = s1_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // accumulate stage
      if (s2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rr_ff) - ACC_W'(p_ii_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_ri_ff) + ACC_W'(p_ir_ff);
      end

      unique case (state_ff)
         cidf_pkg::ST_IDLE: begin
            if (req_acc) begin
               x_re_in   = req_sample_re;
               x_im_in   = req_sample_im;
               acc_re_in = '0;
               acc_im_in = '0;
               cnt_in    = '0;
               state_in  = cidf_pkg::ST_FB;
            end
         end
         cidf_pkg::ST_FB, cidf_pkg::ST_FF: begin
            if (cnt_ff < lim) begin
               rd_en   = 1'b1;
               s1_in   = 1'b1;
               k_s1_in = cnt_ff[1:0];
               cnt_in  = cnt_ff + cidf_pkg::TAPS_W'(1);
            end else if (!s1_ff && !s2_ff) begin
               state_in = bank ? cidf_pkg::ST_DONE : cidf_pkg::ST_WCALC;
            end
         end
         cidf_pkg::ST_WCALC: begin
            wr_en     = 1'b1;
            ptr_in    = ptr_dec;
            acc_re_in = '0;
            acc_im_in = '0;
            cnt_in    = '0;
            state_in  = cidf_pkg::ST_FF;
         end
         cidf_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = cidf_pkg::ST_IDLE;
            end
         end
         default: state_in = cidf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cidf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) vld_ff[ptr_dec] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_re_ff   <= x_re_in;
      x_im_ff   <= x_im_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      k_s1_ff   <= k_s1_in;
      // shared complex multiplier
      p_rr_ff   <= c_re * d_re;
      p_ii_ff   <= c_im * d_im;
      p_ri_ff   <= c_re * d_im;
      p_ir_ff   <= c_im * d_re;
      if (state_ff == cidf_pkg::ST_DONE && out_free) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
      end
   end

   // delay memory ports
   always_ff @(posedge clock) begin
      if (wr_en) delay_ff[ptr_dec] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= delay_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = out_re_ff;
   assign rsp_out_im = out_im_ff;

`ifndef NO_ASSERTIONS
   a_vld_sticky: assert property (@(posedge clock) disable iff (reset)
      (vld_ff & $past(vld_ff)) == $past(vld_ff))
      else $error("delay valid bit cleared outside reset");

   a_drained_at_w: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cidf_pkg::ST_WCALC || state_ff == cidf_pkg::ST_DONE) |-> !s1_ff && !s2_ff)
      else $error("multiply pipeline not empty at end of a tap pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cidf_pkg::ST_DONE))
      else $error("result presented without a finished sample");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PW'(DELAY_DEPTH - 1))
      else $error("write pointer beyond delay depth");
`endif

endmodule
